### design/sckd_pkg.sv
// Package for the scan-code set 1 key event decoder.
// Holds command and event codes, modifier key numbers and the ASCII tables.
// No dependencies.
package sckd_pkg;

  localparam int unsigned KeySlots = 128;
  localparam int unsigned KeyW     = $clog2(KeySlots);

  typedef enum logic [1:0] {
    CMD_RAW   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_MOD   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } event_e;

  localparam logic [KeyW-1:0] KeyLShift = 7'h2A;
  localparam logic [KeyW-1:0] KeyRShift = 7'h36;
  localparam logic [KeyW-1:0] KeyCtrl   = 7'h1D;
  localparam logic [KeyW-1:0] KeyAlt    = 7'h38;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
  } mods_t;

  function automatic mods_t set_modifier(mods_t cur, logic [KeyW-1:0] key, logic value);
    mods_t nxt;
    nxt = cur;
    if (key == KeyLShift || key == KeyRShift) begin
      nxt.shift = value;
    end else if (key == KeyCtrl) begin
      nxt.ctrl = value;
    end else if (key == KeyAlt) begin
      nxt.alt = value;
    end
    return nxt;
  endfunction

  function automatic logic [6:0] to_ascii(logic shift, logic [KeyW-1:0] key);
    logic [6:0] chr;
    case (key)
      7'd1:    chr = 7'h01;
      7'd2:    chr = shift ? 7'h21 : 7'h31;
      7'd3:    chr = shift ? 7'h40 : 7'h32;
      7'd4:    chr = shift ? 7'h23 : 7'h33;
      7'd5:    chr = shift ? 7'h24 : 7'h34;
      7'd6:    chr = shift ? 7'h25 : 7'h35;
      7'd7:    chr = shift ? 7'h5E : 7'h36;
      7'd8:    chr = shift ? 7'h26 : 7'h37;
      7'd9:    chr = shift ? 7'h2A : 7'h38;
      7'd10:   chr = shift ? 7'h28 : 7'h39;
      7'd11:   chr = shift ? 7'h29 : 7'h30;
      7'd12:   chr = shift ? 7'h5F : 7'h2D;
      7'd13:   chr = shift ? 7'h2B : 7'h3D;
      7'd14:   chr = 7'h08;
      7'd15:   chr = 7'h09;
      7'd16:   chr = shift ? 7'h51 : 7'h71;
      7'd17:   chr = shift ? 7'h57 : 7'h77;
      7'd18:   chr = shift ? 7'h45 : 7'h65;
      7'd19:   chr = shift ? 7'h52 : 7'h72;
      7'd20:   chr = shift ? 7'h54 : 7'h74;
      7'd21:   chr = shift ? 7'h59 : 7'h79;
      7'd22:   chr = shift ? 7'h55 : 7'h75;
      7'd23:   chr = shift ? 7'h49 : 7'h69;
      7'd24:   chr = shift ? 7'h4F : 7'h6F;
      7'd25:   chr = shift ? 7'h50 : 7'h70;
      7'd26:   chr = shift ? 7'h7B : 7'h5B;
      7'd27:   chr = shift ? 7'h7D : 7'h5D;
      7'd28:   chr = 7'h0A;
      7'd30:   chr = shift ? 7'h41 : 7'h61;
      7'd31:   chr = shift ? 7'h53 : 7'h73;
      7'd32:   chr = shift ? 7'h44 : 7'h64;
      7'd33:   chr = shift ? 7'h46 : 7'h66;
      7'd34:   chr = shift ? 7'h47 : 7'h67;
      7'd35:   chr = shift ? 7'h48 : 7'h68;
      7'd36:   chr = shift ? 7'h4A : 7'h6A;
      7'd37:   chr = shift ? 7'h4B : 7'h6B;
      7'd38:   chr = shift ? 7'h4C : 7'h6C;
      7'd39:   chr = shift ? 7'h3A : 7'h3B;
      7'd40:   chr = shift ? 7'h22 : 7'h27;
      7'd41:   chr = shift ? 7'h7E : 7'h60;
      7'd43:   chr = shift ? 7'h7C : 7'h5C;
      7'd44:   chr = shift ? 7'h5A : 7'h7A;
      7'd45:   chr = shift ? 7'h58 : 7'h78;
      7'd46:   chr = shift ? 7'h43 : 7'h63;
      7'd47:   chr = shift ? 7'h56 : 7'h76;
      7'd48:   chr = shift ? 7'h42 : 7'h62;
      7'd49:   chr = shift ? 7'h4E : 7'h6E;
      7'd50:   chr = shift ? 7'h4D : 7'h6D;
      7'd51:   chr = shift ? 7'h3C : 7'h2C;
      7'd52:   chr = shift ? 7'h3E : 7'h2E;
      7'd53:   chr = shift ? 7'h3F : 7'h2F;
      7'd55:   chr = 7'h2A;
      7'd57:   chr = 7'h20;
      default: chr = 7'h00;
    endcase
    return chr;
  endfunction

endpackage

### design/scancode_key_event_decoder_core.sv
// Top level of the scan-code set 1 key event decoder.
// Depends on sckd_pkg for codes, modifier helpers and the ASCII tables.
//
// One beat in gives one beat out. A beat is captured in an input register
// together with the held bit of its key, read from the 128-entry key map;
// once it moves on, the result register loads, raw beats write the map
// and raw or modifier beats set the modifier holds. Throughput is one
// beat per cycle, and both stages hold while the output side stalls. The
// key map clears at reset via per-key valid bits; no clearing pass needed.
module scancode_key_event_decoder_core import sckd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      command_i,
  input  logic [7:0]      code_byte_i,
  input  logic            pressed_flag_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      event_kind_o,
  output logic [KeyW-1:0] key_number_o,
  output logic [6:0]      ascii_char_o,
  output logic            shift_held_o,
  output logic            ctrl_held_o,
  output logic            alt_held_o,
  output logic [7:0]      last_code_o,
  output logic            key_is_down_o
);

  logic                s1_valid_q;
  logic [1:0]          cmd_q;
  logic [7:0]          code_q;
  logic                flag_q;
  logic                held_q;

  logic                out_valid_q;
  logic [1:0]          kind_q;
  logic [KeyW-1:0]     keynum_q;
  logic [6:0]          ascii_q;
  logic                down_q;

  mods_t               mods_q, mods_d;
  logic [7:0]          last_q, last_d;

  logic                key_mem [KeySlots];
  logic [KeySlots-1:0] key_vld_q;

  logic                advance;
  logic                fire;
  logic                accept;
  logic [KeyW-1:0]     key;
  logic [KeyW-1:0]     rd_key;
  logic                press;
  logic                wr_en;
  logic [1:0]          kind_d;
  logic [6:0]          ascii_d;
  logic                down_d;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign key    = code_q[KeyW-1:0];
  assign rd_key = code_byte_i[KeyW-1:0];
  assign press  = !code_q[7];
  assign wr_en  = fire && (cmd_q == CMD_RAW);

  always_comb begin
    mods_d  = mods_q;
    last_d  = last_q;
    kind_d  = EV_NONE;
    ascii_d = 7'd0;
    down_d  = 1'b0;
    case (cmd_q)
      CMD_RAW: begin
        mods_d = set_modifier(mods_q, key, press);
        last_d = code_q;
        if (press && !held_q) begin
          kind_d = EV_DOWN;
        end else if (!press && held_q) begin
          kind_d = EV_UP;
        end
        if (press) begin
          ascii_d = to_ascii(mods_d.shift, key);
        end
      end
      CMD_QUERY: begin
        down_d = held_q;
      end
      CMD_MOD: begin
        mods_d = set_modifier(mods_q, key, flag_q);
      end
      default: begin
      end
    endcase
  end

  // Key map storage; bypass the write of the stage ahead on a same-key read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[key] <= press;
    end
    if (accept) begin
      if (wr_en && (key == rd_key)) begin
        held_q <= press;
      end else begin
        held_q <= key_vld_q[rd_key] & key_mem[rd_key];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q <= '0;
    end else if (wr_en) begin
      key_vld_q[key] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mods_q      <= '0;
      last_q      <= 8'd0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire) begin
        mods_q <= mods_d;
        last_q <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      code_q <= code_byte_i;
      flag_q <= pressed_flag_i;
    end
    if (fire) begin
      kind_q   <= kind_d;
      keynum_q <= key;
      ascii_q  <= ascii_d;
      down_q   <= down_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign key_number_o  = keynum_q;
  assign ascii_char_o  = ascii_q;
  assign shift_held_o  = mods_q.shift;
  assign ctrl_held_o   = mods_q.ctrl;
  assign alt_held_o    = mods_q.alt;
  assign last_code_o   = last_q;
  assign key_is_down_o = down_q;

endmodule
